// ----- sv/tspc_pkg.sv -----
// Shared types, constants and the control program of the train speed PI power controller.
`timescale 1ns / 1ps

package tspc_pkg;

    localparam int SPEED_W  = 16;
    localparam int KMH_W    = 8;
    localparam int AUTH_W   = 8;
    localparam int GAIN_W   = 24;
    localparam int PERIOD_W = 16;
    localparam int ERR_W    = 18;
    localparam int ESUM_W   = ERR_W + 1;
    localparam int INT_W    = 40;
    localparam int INT_LO_W = 20;
    localparam int INT_HI_W = INT_W - INT_LO_W;
    localparam int MA_W     = GAIN_W + 1;
    localparam int MB_W     = INT_LO_W + 1;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int ISUM_W   = PROD_W + 1;
    localparam int ACC_W    = 66;
    localparam int PWR_W    = 18;
    localparam int PFULL_W  = ACC_W - 32;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = 3;

    localparam int POWER_LIMIT = 120000;
    localparam int OUT_MAX = 2 ** (PWR_W - 1) - 1;
    localparam int POS_CLAMP = (POWER_LIMIT > OUT_MAX) ? OUT_MAX : POWER_LIMIT;
    localparam int NEG_CLAMP = (POWER_LIMIT > OUT_MAX + 1) ? -(OUT_MAX + 1) : -POWER_LIMIT;
    localparam logic signed [PWR_W-1:0]   POS_CLAMP_OUT  = PWR_W'(POS_CLAMP);
    localparam logic signed [PWR_W-1:0]   NEG_CLAMP_OUT  = PWR_W'(NEG_CLAMP);
    localparam logic signed [PFULL_W-1:0] POS_CLAMP_FULL = PFULL_W'(POS_CLAMP);
    localparam logic signed [PFULL_W-1:0] NEG_CLAMP_FULL = PFULL_W'(NEG_CLAMP);

    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK  = 2'd3;

    localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_INC  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_UK   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PROP = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ILO  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_IHI  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMIT = 3'd6;
    localparam logic [STEP_W-1:0] STEP_CUT  = 3'd7;

    typedef enum logic [1:0] {MA_PERIOD, MA_KP, MA_KI} mul_a_sel_t;
    typedef enum logic [1:0] {MB_ERRSUM, MB_ERR, MB_UK_LO, MB_UK_HI} mul_b_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD_P, ACC_ADD, ACC_ADD_HI} acc_op_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_REQ, SEQ_JUMP_CUT, SEQ_WAIT_OUT} seq_op_t;
    typedef enum logic [1:0] {OUT_NONE, OUT_POWER, OUT_CUT} out_op_t;

    typedef struct packed {
        logic              take_req;
        mul_a_sel_t        mul_a;
        mul_b_sel_t        mul_b;
        logic              uk_load;
        acc_op_t           acc_op;
        out_op_t           out_op;
        seq_op_t           seq;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic req;
        logic interlock;
        logic out_free;
    } seq_status_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [PERIOD_W-1:0] period;
        logic                use_track;
    } cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0] measured_speed;
        logic               service_brake_on;
        logic               emergency_brake_on;
        logic               brake_failed;
        logic [AUTH_W-1:0]  authority_blocks;
        logic [KMH_W-1:0]   speed_limit_kmh;
        logic [KMH_W-1:0]   track_setpoint_kmh;
        logic [KMH_W-1:0]   driver_command_kmh;
    } item_t;

    typedef struct packed {
        logic signed [PWR_W-1:0] power_watts;
        logic                    power_cut;
    } result_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w.take_req = 1'b0;
        w.mul_a    = MA_PERIOD;
        w.mul_b    = MB_ERRSUM;
        w.uk_load  = 1'b0;
        w.acc_op   = ACC_HOLD;
        w.out_op   = OUT_NONE;
        w.seq      = SEQ_NEXT;
        w.target   = STEP_IDLE;
        case (step)
            STEP_IDLE:
            begin
                w.take_req = 1'b1;
                w.seq      = SEQ_WAIT_REQ;
            end
            STEP_INC:
            begin
                w.seq    = SEQ_JUMP_CUT;
                w.target = STEP_CUT;
            end
            STEP_UK:
            begin
                w.uk_load = 1'b1;
                w.mul_a   = MA_KP;
                w.mul_b   = MB_ERR;
            end
            STEP_PROP:
            begin
                w.acc_op = ACC_LOAD_P;
                w.mul_a  = MA_KI;
                w.mul_b  = MB_UK_LO;
            end
            STEP_ILO:
            begin
                w.acc_op = ACC_ADD;
                w.mul_a  = MA_KI;
                w.mul_b  = MB_UK_HI;
            end
            STEP_IHI:
            begin
                w.acc_op = ACC_ADD_HI;
            end
            STEP_EMIT:
            begin
                w.out_op = OUT_POWER;
                w.seq    = SEQ_WAIT_OUT;
                w.target = STEP_IDLE;
            end
            STEP_CUT:
            begin
                w.out_op = OUT_CUT;
                w.seq    = SEQ_WAIT_OUT;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.seq    = SEQ_JUMP_CUT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/tspc_if.sv -----
// Request channels of the train speed PI power controller: sensor sample and power command.
`timescale 1ns / 1ps

interface tspc_sample_if;
    import tspc_pkg::*;
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] measured_speed;
    logic               service_brake_on;
    logic               emergency_brake_on;
    logic               brake_failed;
    logic [AUTH_W-1:0]  authority_blocks;
    logic [KMH_W-1:0]   speed_limit_kmh;
    logic [KMH_W-1:0]   track_setpoint_kmh;
    logic [KMH_W-1:0]   driver_command_kmh;

    modport source (
        output valid, measured_speed, service_brake_on, emergency_brake_on, brake_failed,
               authority_blocks, speed_limit_kmh, track_setpoint_kmh, driver_command_kmh,
        input  ready
    );
    modport sink (
        input  valid, measured_speed, service_brake_on, emergency_brake_on, brake_failed,
               authority_blocks, speed_limit_kmh, track_setpoint_kmh, driver_command_kmh,
        output ready
    );
endinterface

interface tspc_power_if;
    import tspc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [PWR_W-1:0] power_watts;
    logic                    power_cut;

    modport source (output valid, power_watts, power_cut, input ready);
    modport sink (input valid, power_watts, power_cut, output ready);
endinterface

// ----- sv/train_speed_pi_power_controller.sv -----
// Top level of the train speed PI power controller: configuration registers and channel wiring.
`timescale 1ns / 1ps

// Usage
// Each control tick a request on the sample channel carries the measured speed, the brake
// and failure flags, the movement authority and the three target speeds. For each sample
// exactly one request leaves on the power channel with the traction power in whole watts
// and the power_cut flag. Gains, sample period and target source are written through the
// cfg_we / cfg_index / cfg_data port while no sample is in flight.
// A sample runs through an eight-step control program that drives one shared 25x21
// multiplier for four dependent products (integrator step, proportional term, two halves
// of the integral term). The next sample is taken only once the previous one has left its
// output step. A sample with a brake or authority interlock skips the arithmetic and jumps
// straight to the power-cut step.
// The result sits in an output register, so the next sample is accepted while it waits.
// When the receiver stalls, the program holds at its output step until the register frees.
// Reset clears the configuration, the integrator, the previous error and the output valid.
module train_speed_pi_power_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tspc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tspc_pkg::CFG_W-1:0]        cfg_data,
    tspc_sample_if.sink                       sample,
    tspc_power_if.source                      power
);
    import tspc_pkg::*;

    cfg_t        cfg_reg;
    ucode_t      ctrl;
    seq_status_t status;
    item_t       item;
    result_t     result;
    logic        load_item;
    logic        out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KP:     cfg_reg.kp        <= cfg_data[GAIN_W-1:0];
                CFG_KI:     cfg_reg.ki        <= cfg_data[GAIN_W-1:0];
                CFG_PERIOD: cfg_reg.period    <= cfg_data[PERIOD_W-1:0];
                CFG_TRACK:  cfg_reg.use_track <= cfg_data[0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign item.measured_speed     = sample.measured_speed;
    assign item.service_brake_on   = sample.service_brake_on;
    assign item.emergency_brake_on = sample.emergency_brake_on;
    assign item.brake_failed       = sample.brake_failed;
    assign item.authority_blocks   = sample.authority_blocks;
    assign item.speed_limit_kmh    = sample.speed_limit_kmh;
    assign item.track_setpoint_kmh = sample.track_setpoint_kmh;
    assign item.driver_command_kmh = sample.driver_command_kmh;

    assign sample.ready = ctrl.take_req;
    assign load_item    = sample.valid && ctrl.take_req;

    tspc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    tspc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .load_item (load_item),
        .item      (item),
        .out_ready (power.ready),
        .status    (status),
        .out_valid (out_valid),
        .result    (result)
    );

    assign power.valid       = out_valid;
    assign power.power_watts = result.power_watts;
    assign power.power_cut   = result.power_cut;

endmodule

// ----- sv/tspc_sequencer.sv -----
// Step counter and control program store that sequence one control tick.
`timescale 1ns / 1ps

module tspc_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tspc_pkg::seq_status_t status,
    output tspc_pkg::ucode_t     ctrl
);
    import tspc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_inc;

    assign ctrl     = ucode_rom(step_reg);
    assign step_inc = STEP_W'(step_reg + 1'b1);

    always_comb
    begin
        case (ctrl.seq)
            SEQ_NEXT:     step_next = step_inc;
            SEQ_WAIT_REQ: step_next = status.req ? step_inc : step_reg;
            SEQ_JUMP_CUT: step_next = status.interlock ? ctrl.target : step_inc;
            SEQ_WAIT_OUT: step_next = status.out_free ? ctrl.target : step_reg;
            default:      step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- sv/tspc_datapath.sv -----
// Datapath: sample latch, error, shared multiplier, integrator, accumulator and result register.
`timescale 1ns / 1ps

module tspc_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tspc_pkg::cfg_t        cfg,
    input  tspc_pkg::ucode_t      ctrl,
    input  logic                  load_item,
    input  tspc_pkg::item_t       item,
    input  logic                  out_ready,
    output tspc_pkg::seq_status_t status,
    output logic                  out_valid,
    output tspc_pkg::result_t     result
);
    import tspc_pkg::*;

    item_t                      item_reg;
    logic signed [INT_W-1:0]    integral_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [INT_W-1:0]    uk_reg;
    logic signed [INT_W-1:0]    uk_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       out_valid_reg;
    result_t                    result_reg;

    logic                       interlock;
    logic                       over_limit;
    logic [SPEED_W-1:0]         limit_speed;
    logic [SPEED_W-1:0]         target;
    logic signed [ERR_W-1:0]    err;
    logic signed [ESUM_W-1:0]   err_sum;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   inc;
    logic signed [ISUM_W-1:0]   int_sum;
    logic signed [PFULL_W-1:0]  power_full;
    logic signed [PWR_W-1:0]    power_clamped;
    logic                       out_free;
    logic                       emit;

    assign interlock = item_reg.service_brake_on | item_reg.emergency_brake_on
                     | item_reg.brake_failed | (item_reg.authority_blocks == '0);

    assign limit_speed = {item_reg.speed_limit_kmh, 8'h00};
    assign over_limit  = item_reg.measured_speed > limit_speed;

    always_comb
    begin
        if (over_limit)
        begin
            target = limit_speed;
        end
        else if (cfg.use_track)
        begin
            target = {item_reg.track_setpoint_kmh, 8'h00};
        end
        else
        begin
            target = {item_reg.driver_command_kmh, 8'h00};
        end
    end

    assign err     = $signed({2'b00, target}) - $signed({2'b00, item_reg.measured_speed});
    assign err_sum = ESUM_W'(err) + ESUM_W'(prev_err_reg);

    always_comb
    begin
        case (ctrl.mul_a)
            MA_PERIOD: mul_a = $signed({{(MA_W - PERIOD_W){1'b0}}, cfg.period});
            MA_KP:     mul_a = $signed({1'b0, cfg.kp});
            MA_KI:     mul_a = $signed({1'b0, cfg.ki});
            default:   mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.mul_b)
            MB_ERRSUM: mul_b = MB_W'(err_sum);
            MB_ERR:    mul_b = MB_W'(err);
            MB_UK_LO:  mul_b = $signed({1'b0, uk_reg[INT_LO_W-1:0]});
            MB_UK_HI:  mul_b = MB_W'($signed(uk_reg[INT_W-1:INT_LO_W]));
            default:   mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // The integrator step is halved with floor rounding, then added and saturated.
    assign inc     = prod_reg >>> 1;
    assign int_sum = ISUM_W'(integral_reg) + ISUM_W'(inc);

    always_comb
    begin
        if (int_sum[ISUM_W-1:INT_W-1] == '0 || int_sum[ISUM_W-1:INT_W-1] == '1)
        begin
            uk_next = int_sum[INT_W-1:0];
        end
        else if (int_sum[ISUM_W-1])
        begin
            uk_next = {1'b1, {(INT_W - 1){1'b0}}};
        end
        else
        begin
            uk_next = {1'b0, {(INT_W - 1){1'b1}}};
        end
    end

    // The accumulator holds kp*e*2^16 + ki*u, so its upper bits are the power in watts.
    always_comb
    begin
        case (ctrl.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD_P: acc_next = ACC_W'(prod_reg) <<< 16;
            ACC_ADD:    acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_ADD_HI: acc_next = acc_reg + {prod_reg, {INT_LO_W{1'b0}}};
            default:    acc_next = acc_reg;
        endcase
    end

    assign power_full = acc_reg[ACC_W-1:32];

    always_comb
    begin
        if (power_full > POS_CLAMP_FULL)
        begin
            power_clamped = POS_CLAMP_OUT;
        end
        else if (power_full < NEG_CLAMP_FULL)
        begin
            power_clamped = NEG_CLAMP_OUT;
        end
        else
        begin
            power_clamped = power_full[PWR_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = (ctrl.out_op != OUT_NONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit && ctrl.out_op == OUT_POWER)
            begin
                integral_reg <= uk_reg;
                prev_err_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= item;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctrl.uk_load)
        begin
            uk_reg <= uk_next;
        end
        if (emit)
        begin
            if (ctrl.out_op == OUT_CUT)
            begin
                result_reg.power_watts <= '0;
                result_reg.power_cut   <= 1'b1;
            end
            else
            begin
                result_reg.power_watts <= power_clamped;
                result_reg.power_cut   <= 1'b0;
            end
        end
    end

    assign status.req       = load_item;
    assign status.interlock = interlock;
    assign status.out_free  = out_free;
    assign out_valid        = out_valid_reg;
    assign result           = result_reg;

endmodule

// ----- sv/tspc_checker.sv -----
// Port-level assertions for the train speed PI power controller and their bind.
`timescale 1ns / 1ps

module tspc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tspc_pkg::PWR_W-1:0]    power_watts,
    input logic                          power_cut
);
    import tspc_pkg::*;

    // One sample is worked on at a time, so the block is busy right after taking one.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample channel ready right after a request was taken");

    a_cut_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && power_cut |-> power_watts == '0)
        else $error("power cut with nonzero power");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(power_watts) <= POS_CLAMP_OUT)
                   && ($signed(power_watts) >= NEG_CLAMP_OUT))
        else $error("power outside the clamp range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_watts) && $stable(power_cut))
        else $error("stalled power request changed");

endmodule

bind train_speed_pi_power_controller tspc_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (power.valid),
    .out_ready   (power.ready),
    .power_watts (power.power_watts),
    .power_cut   (power.power_cut)
);

// ----- test/testbench.sv -----
// Self-checking testbench of the train speed PI power controller.
`timescale 1ns / 1ps

module testbench;
    import tspc_pkg::*;

    typedef enum {DRIFT_MIXED, DRIFT_RISE, DRIFT_FALL} drift_t;

    typedef struct {
        int unsigned setting;
        item_t       sample;
        bit          typed;
        result_t     want;
    } dir_row_t;

    localparam longint INTEGRAL_MAX = (64'sd1 <<< 39) - 64'sd1;
    localparam longint INTEGRAL_MIN = -(64'sd1 <<< 39);
    localparam longint FIELD_MAX    = 131071;
    localparam longint FIELD_MIN    = -131072;
    localparam int     SETTLE       = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tspc_sample_if sample_ch ();
    tspc_power_if  power_ch ();

    train_speed_pi_power_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .power     (power_ch)
    );

    cfg_t                gains;
    logic signed [39:0]  speed_integral;
    logic signed [17:0]  last_speed_error;
    result_t             power_due[$];
    dir_row_t            directed[$];
    cfg_t                directed_gains[3];
    int                  failures;
    int                  send_run;
    bit                  send_calm;
    int                  take_run;
    bit                  take_calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int draw_gap(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            calm     = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(8, 40);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // Advances the controller state for one accepted sample and returns its power command.
    function automatic result_t next_power_command(item_t s);
        result_t r;
        longint  speed;
        longint  ceiling;
        longint  goal;
        longint  err;
        longint  step;
        longint  acc;
        longint  prop;
        longint  watts;
        r.power_watts = '0;
        r.power_cut   = 1'b1;
        if (s.service_brake_on || s.emergency_brake_on || s.brake_failed ||
            s.authority_blocks == '0)
            return r;
        speed   = longint'(s.measured_speed);
        ceiling = longint'(s.speed_limit_kmh) <<< 8;
        if (speed > ceiling)
            goal = ceiling;
        else if (gains.use_track)
            goal = longint'(s.track_setpoint_kmh) <<< 8;
        else
            goal = longint'(s.driver_command_kmh) <<< 8;
        err  = goal - speed;
        step = (longint'(gains.period) * (err + longint'(last_speed_error))) >>> 1;
        acc  = longint'(speed_integral) + step;
        if (acc > INTEGRAL_MAX)
            acc = INTEGRAL_MAX;
        if (acc < INTEGRAL_MIN)
            acc = INTEGRAL_MIN;
        prop  = longint'(gains.kp) * err + ((longint'(gains.ki) * acc) >>> 16);
        watts = prop >>> 16;
        if (watts > POWER_LIMIT)
            watts = POWER_LIMIT;
        if (watts < -POWER_LIMIT)
            watts = -POWER_LIMIT;
        if (watts > FIELD_MAX)
            watts = FIELD_MAX;
        if (watts < FIELD_MIN)
            watts = FIELD_MIN;
        speed_integral   = 40'(acc);
        last_speed_error = 18'(err);
        r.power_watts    = 18'(watts);
        r.power_cut      = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t row(int unsigned setting, item_t s, bit typed = 1'b0,
                                     int watts = 0, bit cut = 1'b0);
        dir_row_t d;
        d.setting           = setting;
        d.sample            = s;
        d.typed             = typed;
        d.want.power_watts  = 18'(watts);
        d.want.power_cut    = cut;
        return d;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        return GAIN_W'($urandom) >> $urandom_range(0, 20);
    endfunction

    function automatic item_t random_sample(drift_t drift);
        item_t s;
        logic [KMH_W-1:0] aim;
        s.service_brake_on   = 1'b0;
        s.emergency_brake_on = 1'b0;
        s.brake_failed       = 1'b0;
        s.authority_blocks   = 8'($urandom_range(1, 255));
        s.track_setpoint_kmh = 8'($urandom);
        s.driver_command_kmh = 8'($urandom);
        if (drift == DRIFT_MIXED || $urandom_range(0, 9) == 0)
        begin
            s.service_brake_on   = ($urandom_range(0, 7) == 0);
            s.emergency_brake_on = ($urandom_range(0, 7) == 0);
            s.brake_failed       = ($urandom_range(0, 7) == 0);
            s.authority_blocks   = ($urandom_range(0, 15) == 0) ? '0 : 8'($urandom);
            s.speed_limit_kmh    = 8'($urandom);
            aim = gains.use_track ? s.track_setpoint_kmh : s.driver_command_kmh;
            if ($urandom_range(0, 1) == 0)
                s.measured_speed = 16'($urandom);
            else
                s.measured_speed = {aim, 8'h00} + 16'($urandom_range(0, 2047)) - 16'd1024;
        end
        else if (drift == DRIFT_RISE)
        begin
            s.speed_limit_kmh    = 8'($urandom_range(250, 255));
            s.track_setpoint_kmh = 8'($urandom_range(240, 255));
            s.driver_command_kmh = 8'($urandom_range(240, 255));
            s.measured_speed     = 16'($urandom_range(0, 16'h0FFF));
        end
        else
        begin
            s.speed_limit_kmh = 8'($urandom_range(0, 15));
            s.measured_speed  = 16'($urandom_range(16'hF000, 16'hFFFF));
        end
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                             input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_gains(input cfg_t c);
        write_reg(CFG_KP, c.kp);
        write_reg(CFG_KI, c.ki);
        write_reg(CFG_PERIOD, {8'($urandom), c.period});
        write_reg(CFG_TRACK, {23'($urandom), c.use_track});
        cfg_we <= 1'b0;
        gains = c;
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (power_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic offer_sample(input item_t s, input bit typed, input result_t want);
        int      gap;
        result_t due;
        gap = draw_gap(send_run, send_calm);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid              <= 1'b1;
        sample_ch.measured_speed     <= s.measured_speed;
        sample_ch.service_brake_on   <= s.service_brake_on;
        sample_ch.emergency_brake_on <= s.emergency_brake_on;
        sample_ch.brake_failed       <= s.brake_failed;
        sample_ch.authority_blocks   <= s.authority_blocks;
        sample_ch.speed_limit_kmh    <= s.speed_limit_kmh;
        sample_ch.track_setpoint_kmh <= s.track_setpoint_kmh;
        sample_ch.driver_command_kmh <= s.driver_command_kmh;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        due = next_power_command(s);
        power_due.push_back(typed ? want : due);
    endtask

    initial
    begin : power_sink
        int gap;
        power_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(take_run, take_calm);
            if (gap != 0)
            begin
                power_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            power_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!power_ch.valid);
        end
    end

    always @(posedge clk)
    begin : power_check
        result_t want;
        if (rst_n && power_ch.valid && power_ch.ready)
        begin
            if (power_due.size() == 0)
            begin
                $display("%0t: power request with none expected, got power %0d cut %0b",
                         $time, power_ch.power_watts, power_ch.power_cut);
                failures++;
            end
            else
            begin
                want = power_due.pop_front();
                if (power_ch.power_watts !== want.power_watts)
                begin
                    $display("%0t: power_watts expected %0d got %0d",
                             $time, want.power_watts, power_ch.power_watts);
                    failures++;
                end
                if (power_ch.power_cut !== want.power_cut)
                begin
                    $display("%0t: power_cut expected %0b got %0b",
                             $time, want.power_cut, power_ch.power_cut);
                    failures++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned current;
        int          phase;
        int          count;
        drift_t      drift;
        cfg_t        g;
        result_t     none;
        rst_n                        = 1'b0;
        cfg_we                       = 1'b0;
        cfg_index                    = '0;
        cfg_data                     = '0;
        sample_ch.valid              = 1'b0;
        sample_ch.measured_speed     = '0;
        sample_ch.service_brake_on   = 1'b0;
        sample_ch.emergency_brake_on = 1'b0;
        sample_ch.brake_failed       = 1'b0;
        sample_ch.authority_blocks   = '0;
        sample_ch.speed_limit_kmh    = '0;
        sample_ch.track_setpoint_kmh = '0;
        sample_ch.driver_command_kmh = '0;
        gains                        = '0;
        speed_integral               = '0;
        last_speed_error             = '0;
        failures                     = 0;
        send_run                     = 0;
        send_calm                    = 1'b0;
        take_run                     = 0;
        take_calm                    = 1'b0;
        none                         = '0;

        directed_gains[0] = '0;
        directed_gains[1] = '{kp: 24'hFFFFFF, ki: 24'h0, period: 16'hFFFF, use_track: 1'b1};
        directed_gains[2] = '{kp: 24'h000180, ki: 24'h000100, period: 16'h1999, use_track: 1'b0};

        // With all gains still at their reset values every command is zero.
        directed.push_back(row(0, item_t'{16'h1234, 0, 0, 0, 8'd10, 8'd80, 8'd60, 8'd50}, 1, 0, 0));
        directed.push_back(row(0, item_t'{16'h1234, 1, 0, 0, 8'd10, 8'd80, 8'd60, 8'd50}, 1, 0, 1));
        directed.push_back(row(0, item_t'{16'h1234, 0, 1, 0, 8'd10, 8'd80, 8'd60, 8'd50}, 1, 0, 1));
        directed.push_back(row(0, item_t'{16'h1234, 0, 0, 1, 8'd10, 8'd80, 8'd60, 8'd50}, 1, 0, 1));
        directed.push_back(row(0, item_t'{16'h1234, 0, 0, 0, 8'd0, 8'd80, 8'd60, 8'd50}, 1, 0, 1));
        directed.push_back(row(0, item_t'{16'hFFFF, 1, 1, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1, 0, 1));
        directed.push_back(row(0, item_t'{16'hFFFF, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1, 0, 0));
        directed.push_back(row(0, item_t'{16'h0000, 0, 0, 0, 8'd1, 8'd0, 8'd0, 8'd0}, 1, 0, 0));
        // Full proportional gain and no integral term drive the clamp both ways.
        directed.push_back(row(1, item_t'{16'h0000, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h00},
                               1, POWER_LIMIT, 0));
        directed.push_back(row(1, item_t'{16'hFFFF, 0, 0, 0, 8'hFF, 8'h00, 8'hFF, 8'hFF},
                               1, -POWER_LIMIT, 0));
        directed.push_back(row(1, item_t'{16'hC800, 0, 0, 0, 8'd5, 8'hFF, 8'd200, 8'd0}, 1, 0, 0));
        directed.push_back(row(1, item_t'{16'h1000, 0, 0, 0, 8'd5, 8'd16, 8'd16, 8'd90}, 1, 0, 0));
        directed.push_back(row(1, item_t'{16'h1001, 0, 0, 0, 8'd5, 8'd16, 8'd16, 8'd90}));
        directed.push_back(row(1, item_t'{16'h0000, 0, 1, 0, 8'd5, 8'hFF, 8'hFF, 8'hFF}, 1, 0, 1));
        directed.push_back(row(2, item_t'{16'h0000, 0, 0, 0, 8'd20, 8'hFF, 8'd200, 8'd100}));
        directed.push_back(row(2, item_t'{16'h3200, 0, 0, 0, 8'd20, 8'hFF, 8'd200, 8'd100}));
        directed.push_back(row(2, item_t'{16'h7800, 0, 0, 0, 8'd20, 8'd110, 8'd200, 8'd100}));
        directed.push_back(row(2, item_t'{16'h7800, 1, 0, 0, 8'd20, 8'd110, 8'd200, 8'd100},
                               1, 0, 1));
        directed.push_back(row(2, item_t'{16'h6400, 0, 0, 0, 8'd20, 8'd110, 8'd200, 8'd100}));
        directed.push_back(row(2, item_t'{16'h6400, 0, 0, 0, 8'd0, 8'd110, 8'd200, 8'd100},
                               1, 0, 1));
        directed.push_back(row(2, item_t'{16'hFFFF, 0, 0, 0, 8'd1, 8'hFF, 8'hFF, 8'hFF}));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        current = 0;
        foreach (directed[i])
        begin
            if (directed[i].setting != current)
            begin
                drain();
                current = directed[i].setting;
                apply_gains(directed_gains[current]);
            end
            offer_sample(directed[i].sample, directed[i].typed, directed[i].want);
        end

        // Random phases; the long falling and rising runs at full period push the
        // integrator into saturation in both directions.
        for (phase = 0; phase < 5; phase++)
        begin
            g.kp        = rand_gain();
            g.ki        = rand_gain();
            g.period    = 16'($urandom);
            g.use_track = 1'($urandom_range(0, 1));
            case (phase)
                0:
                begin
                    drift = DRIFT_MIXED;
                    count = 90;
                end
                1:
                begin
                    g.period = 16'hFFFF;
                    drift    = DRIFT_FALL;
                    count    = 170;
                end
                2:
                begin
                    g.period = 16'hFFFF;
                    drift    = DRIFT_RISE;
                    count    = 340;
                end
                3:
                begin
                    g.kp  = 24'hFFFFFF;
                    g.ki  = 24'hFFFFFF;
                    drift = DRIFT_MIXED;
                    count = 80;
                end
                default:
                begin
                    g.kp     = '0;
                    g.period = '0;
                    drift    = DRIFT_MIXED;
                    count    = 70;
                end
            endcase
            drain();
            apply_gains(g);
            repeat (count) offer_sample(random_sample(drift), 1'b0, none);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
